>>> design/palette_image_blit_macros.svh
// Assertion macros used by the palette image blit top level.
`ifndef PALETTE_IMAGE_BLIT_MACROS_SVH
`define PALETTE_IMAGE_BLIT_MACROS_SVH

`ifndef SYNTHESIS

`define PIB_ASSERT_SAME(label, cond_a, cond_b) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_b)) \
      else $error("same-cycle check failed");

`define PIB_ASSERT_NEXT(label, cond_a, cond_b) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_b)) \
      else $error("next-cycle check failed");

`else

`define PIB_ASSERT_SAME(label, cond_a, cond_b)

`define PIB_ASSERT_NEXT(label, cond_a, cond_b)

`endif

`endif

>>> design/pib_pkg.sv
// Shared types, constants and arithmetic helpers of the palette image blit.
package pib_pkg;

   localparam int SCREEN_WIDTH    = 480;
   localparam int SCREEN_HEIGHT   = 240;
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
   localparam int PAL_DATA_W      = 32;
   localparam int COORD_W         = 18;
   localparam int CSR_ADDR_W      = 5;

   localparam logic [COORD_W-1:0] SCREEN_X = COORD_W'(SCREEN_WIDTH);
   localparam logic [COORD_W-1:0] SCREEN_Y = COORD_W'(SCREEN_HEIGHT);

   localparam logic [10:0] HEADER_BYTES = 11'd4;
   localparam logic [10:0] PREFIX_BYTES = 11'd1028;
   localparam logic [1:0]  CH_ALPHA     = 2'd3;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

   localparam logic [2:0] REG_BLEND_COLOR    = 3'd0;
   localparam logic [2:0] REG_HORIZ_CENTER   = 3'd1;
   localparam logic [2:0] REG_HORIZ_POSITION = 3'd2;
   localparam logic [2:0] REG_VERT_CENTER    = 3'd3;
   localparam logic [2:0] REG_VERT_POSITION  = 3'd4;

   typedef logic [COORD_W-1:0] coord_type;

   typedef enum logic {
      OP_WRITE,
      OP_PIXEL
   } op_type;

   typedef struct packed {
      logic [23:0] blend_color;
      logic        horiz_center;
      logic [9:0]  horiz_position;
      logic        vert_center;
      logic [8:0]  vert_position;
   } cfg_type;

   typedef struct packed {
      op_type                op;
      logic [PAL_ADDR_W-1:0] index;
      logic [7:0]            alpha;
      logic [23:0]           color;
      logic [2:0][15:0]      prod_c;
      logic [2:0][15:0]      prod_bg;
      coord_type             pixel_x;
      coord_type             pixel_y;
      logic                  last;
   } s1_type;

   typedef struct packed {
      logic s2_valid;
      logic s2_draw;
      logic s2_ready;
   } stat_type;

   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return s[15:8];
   endfunction

   function automatic coord_type place(input logic center, input coord_type pos,
                                       input coord_type screen, input logic [15:0] size);
      coord_type diff;
      coord_type half;
      diff = screen - {2'b0, size};
      half = diff + {17'b0, diff[17]};
      if (center) begin
         return {half[17], half[17:1]};
      end else if (!pos[17]) begin
         return pos;
      end else begin
         return screen + pos - {2'b0, size};
      end
   endfunction

endpackage

>>> design/pib_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pib_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/pib_csr.sv
// Configuration register file behind the APB-style port.
module pib_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pib_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output pib_pkg::cfg_type               cfg
);
   import pib_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[4:2])
            REG_BLEND_COLOR:    cfg_in.blend_color    = csr_pwdata[23:0];
            REG_HORIZ_CENTER:   cfg_in.horiz_center   = csr_pwdata[0];
            REG_HORIZ_POSITION: cfg_in.horiz_position = csr_pwdata[9:0];
            REG_VERT_CENTER:    cfg_in.vert_center    = csr_pwdata[0];
            REG_VERT_POSITION:  cfg_in.vert_position  = csr_pwdata[8:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_BLEND_COLOR:    csr_prdata = {8'b0, cfg_ff.blend_color};
         REG_HORIZ_CENTER:   csr_prdata = {31'b0, cfg_ff.horiz_center};
         REG_HORIZ_POSITION: csr_prdata = {22'b0, cfg_ff.horiz_position};
         REG_VERT_CENTER:    csr_prdata = {31'b0, cfg_ff.vert_center};
         REG_VERT_POSITION:  csr_prdata = {23'b0, cfg_ff.vert_position};
         default:            csr_prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> design/pib_parse.sv
// Input register and stream parser: header, palette entries and pixel raster.
module pib_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tuser,
   input  pib_pkg::cfg_type cfg,
   output logic             s1_valid,
   output pib_pkg::s1_type  s1,
   input  logic             s1_ready
);
   import pib_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_first_ff;
   logic        s1_free;
   logic        s0_move;

   logic [10:0] header_count_ff, header_count_in;
   logic [15:0] image_width_ff, image_width_in;
   logic [15:0] image_height_ff, image_height_in;
   coord_type   origin_x_ff, origin_x_in;
   coord_type   origin_y_ff, origin_y_in;
   logic [15:0] column_count_ff, column_count_in;
   logic [15:0] row_count_ff, row_count_in;
   logic [23:0] channel_hold_ff, channel_hold_in;

   logic        s1_valid_ff;
   s1_type      s1_ff, s1_in;
   logic        emit;

   assign s1_free    = !s1_valid_ff || s1_ready;
   assign s0_move    = in_valid_ff && s1_free;
   assign req_tready = !in_valid_ff || s1_free;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      logic [10:0] hc;
      logic [10:0] off;
      logic [15:0] height_new;
      logic [16:0] col_next;
      logic [15:0] row_new;
      hc               = in_first_ff ? 11'd0 : header_count_ff;
      off              = hc - HEADER_BYTES;
      height_new       = {image_height_ff[15:8], in_byte_ff};
      col_next         = {1'b0, column_count_ff} + 17'd1;
      row_new          = row_count_ff;
      header_count_in  = header_count_ff;
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      origin_x_in      = origin_x_ff;
      origin_y_in      = origin_y_ff;
      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      channel_hold_in  = channel_hold_ff;
      emit             = 1'b0;
      s1_in            = '0;
      s1_in.op         = OP_WRITE;
      s1_in.index      = in_byte_ff;
      s1_in.alpha      = in_byte_ff;
      s1_in.color      = channel_hold_ff;
      for (int i = 0; i < 3; i++) begin
         s1_in.prod_c[i]  = {8'b0, channel_hold_ff[8*i +: 8]} * {8'b0, in_byte_ff};
         s1_in.prod_bg[i] = {8'b0, cfg.blend_color[8*i +: 8]} *
                            {8'b0, ALPHA_OPAQUE - in_byte_ff};
      end
      if (hc < HEADER_BYTES) begin
         header_count_in = hc + 11'd1;
         case (hc[1:0])
            2'd0: image_width_in[15:8]  = in_byte_ff;
            2'd1: image_width_in[7:0]   = in_byte_ff;
            2'd2: image_height_in[15:8] = in_byte_ff;
            default: begin
               image_height_in = height_new;
               origin_x_in     = place(cfg.horiz_center,
                                       {{8{cfg.horiz_position[9]}}, cfg.horiz_position},
                                       SCREEN_X, image_width_ff);
               origin_y_in     = place(cfg.vert_center,
                                       {{9{cfg.vert_position[8]}}, cfg.vert_position},
                                       SCREEN_Y, height_new);
               column_count_in = 16'd0;
               row_count_in    = 16'd0;
            end
         endcase
      end else if (hc < PREFIX_BYTES) begin
         header_count_in = hc + 11'd1;
         s1_in.index     = off[9:2];
         if (off[1:0] != CH_ALPHA) begin
            channel_hold_in = {channel_hold_ff[15:0], in_byte_ff};
         end else begin
            emit = 1'b1;
         end
      end else if (row_count_ff < image_height_ff) begin
         emit          = 1'b1;
         s1_in.op      = OP_PIXEL;
         s1_in.pixel_x = origin_x_ff + {2'b0, column_count_ff};
         s1_in.pixel_y = origin_y_ff + {2'b0, row_count_ff};
         if (col_next >= {1'b0, image_width_ff}) begin
            column_count_in = 16'd0;
            row_new         = row_count_ff + 16'd1;
         end else begin
            column_count_in = col_next[15:0];
         end
         row_count_in = row_new;
         s1_in.last   = (row_new >= image_height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         s1_valid_ff     <= 1'b0;
         header_count_ff <= '0;
         image_width_ff  <= '0;
         image_height_ff <= '0;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         channel_hold_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (s1_free) begin
            s1_valid_ff <= s0_move && emit;
         end
         if (s0_move) begin
            header_count_ff <= header_count_in;
            image_width_ff  <= image_width_in;
            image_height_ff <= image_height_in;
            origin_x_ff     <= origin_x_in;
            origin_y_ff     <= origin_y_in;
            column_count_ff <= column_count_in;
            row_count_ff    <= row_count_in;
            channel_hold_ff <= channel_hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
      if (s0_move) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;
endmodule

>>> design/pib_palette.sv
// Palette blend and store, palette lookup stage and result register.
module pib_palette (
   input  logic              clock,
   input  logic              reset,
   input  logic              s1_valid,
   input  pib_pkg::s1_type   s1,
   output logic              s1_ready,
   output pib_pkg::stat_type stat,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,
   output logic              rsp_tlast
);
   import pib_pkg::*;

   logic [23:0]           blended;
   logic [23:0]           entry_color;
   logic                  s1_move;
   logic                  wr_en;
   logic                  rd_en;
   logic [PAL_DATA_W-1:0] rd_data;

   logic      s2_valid_ff;
   coord_type s2_x_ff, s2_y_ff;
   logic      s2_last_ff;
   logic      s2_draw;
   logic      s2_ready;

   logic        out_free;
   logic        rsp_valid_ff;
   coord_type   rsp_x_ff, rsp_y_ff;
   logic [23:0] rsp_color_ff;
   logic        rsp_last_ff;

   always_comb begin
      logic [8:0] sum;
      blended = '0;
      for (int i = 0; i < 3; i++) begin
         sum = {1'b0, div255(s1.prod_c[i])} + {1'b0, div255(s1.prod_bg[i])};
         blended[8*i +: 8] = sum[7:0];
      end
   end

   assign entry_color = (s1.alpha == ALPHA_OPAQUE) ? s1.color : blended;

   assign s2_draw  = rd_data[31:24] != 8'd0;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s2_ready = !s2_valid_ff || !s2_draw || out_free;
   assign s1_ready = s2_ready;
   assign s1_move  = s1_valid && s1_ready;
   assign wr_en    = s1_move && (s1.op == OP_WRITE);
   assign rd_en    = s1_move && (s1.op == OP_PIXEL);

   pib_ram #(
      .WIDTH(PAL_DATA_W),
      .DEPTH(PALETTE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(s1.index),
      .wr_data({s1.alpha, entry_color}),
      .rd_en  (rd_en),
      .rd_addr(s1.index),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= rd_en;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff && s2_draw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s2_x_ff    <= s1.pixel_x;
         s2_y_ff    <= s1.pixel_y;
         s2_last_ff <= s1.last;
      end
      if (out_free && s2_valid_ff && s2_draw) begin
         rsp_x_ff     <= s2_x_ff;
         rsp_y_ff     <= s2_y_ff;
         rsp_color_ff <= rd_data[23:0];
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign stat.s2_valid = s2_valid_ff;
   assign stat.s2_draw  = s2_draw;
   assign stat.s2_ready = s2_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_color_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;
endmodule

>>> design/palette_image_blit.sv
// Top level of the palette image blit: indexed-color image decode to screen pixels.
// A pixel byte goes from the input register via stage 1 and the lookup stage to rsp.
// One byte is taken every cycle; only a stalled result register with a full
// palette lookup stage behind it holds the input back.
// Reset clears the parser, the pipeline valids and the config registers; the palette RAM
// is not cleared and is filled by each image's palette entries before any lookup.
`include "palette_image_blit_macros.svh"

module palette_image_blit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // byte_value
   input  logic                           req_tuser,  // first_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,  // pixel_x, pixel_y, pixel_color
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pib_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import pib_pkg::*;

   cfg_type  cfg;
   logic     s1_valid;
   s1_type   s1;
   logic     s1_ready;
   stat_type stat;

   pib_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   pib_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cfg       (cfg),
      .s1_valid  (s1_valid),
      .s1        (s1),
      .s1_ready  (s1_ready)
   );

   pib_palette u_palette (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1        (s1),
      .s1_ready  (s1_ready),
      .stat      (stat),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   `PIB_ASSERT_SAME(a_stall_from_output, !req_tready, rsp_tvalid && !rsp_tready)
   `PIB_ASSERT_NEXT(a_lookup_enters, s1_valid && s1_ready && s1.op == OP_PIXEL, stat.s2_valid)
   `PIB_ASSERT_SAME(a_result_from_lookup, $rose(rsp_tvalid), $past(stat.s2_valid && stat.s2_draw))
endmodule
